// ----- rtl/acrr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acrr_pkg
// shared field widths, operation and result codes, result record type
// ----------------------------------------------------------------------------
package acrr_pkg;

	localparam int OP_W     = 2;
	localparam int MASK_W   = 8;
	localparam int SAMPLE_W = 12;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 3;
	localparam int EN_W     = 8;

	localparam logic [OP_W-1:0] OP_REQUEST   = 2'd0;
	localparam logic [OP_W-1:0] OP_INTERRUPT = 2'd1;
	localparam logic [OP_W-1:0] OP_ERROR     = 2'd2;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/acrr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acrr request and result channels
// valid/ready channels carrying scheduler requests and scheduler results
// ----------------------------------------------------------------------------
interface acrr_req_if import acrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [MASK_W-1:0]   request_mask;
	logic                eoc_flag;
	logic [SAMPLE_W-1:0] sample;
	logic                adc_ready;

	modport source (output valid, operation, request_mask, eoc_flag, sample, adc_ready,
		input ready);
	modport sink (input valid, operation, request_mask, eoc_flag, sample, adc_ready,
		output ready);
endinterface

interface acrr_res_if import acrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot;
	logic [SAMPLE_W-1:0] value;
	logic                last;

	modport source (output valid, kind, slot, value, last, input ready);
	modport sink (input valid, kind, slot, value, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/adc_round_robin_conversion_scheduler_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_round_robin_conversion_scheduler_core
// Schedules single ADC conversions over SLOTS channel slots in round-robin
// order. The req channel takes one request per cycle while the result queue
// has room: a slot request, a conversion-end interrupt or an error event.
// Each request gives zero, one or two results on the res channel (a done/error
// report, then a start command); the last result of a request has last set.
// cfg_we/cfg_wdata write the slot enable register; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// A request is registered, then processed once the four-entry result queue
// has room for two more results, and its results are written into the queue.
// Throughput: one request per cycle while the queue has room for two more
// results; the res channel moves one result per cycle.
// When the receiver stalls, the queue fills and req.ready drops once fewer
// than two entries are free; nothing is lost.
// Reset clears pending requests, the round-robin position, the busy flag,
// the active slot, the slot enables and the result queue.
// ----------------------------------------------------------------------------
module adc_round_robin_conversion_scheduler_core import acrr_pkg::*; #(
	parameter int SLOTS       = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [EN_W-1:0] cfg_wdata,
	acrr_req_if.sink           req,
	acrr_res_if.source         res
);

	localparam int SEL_W = $clog2(SLOTS);
	localparam logic [SAMPLE_W-1:0] SAMPLE_KEEP = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
		SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	logic [EN_W-1:0]     slot_enable_q;
	logic [SLOTS-1:0]    pending_q;
	logic [SEL_W-1:0]    rr_q;
	logic                busy_q;
	logic [SEL_W-1:0]    active_q;

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [MASK_W-1:0]   mask_s1;
	logic                eoc_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                ready_s1;

	logic                room2;
	logic                fire;
	logic [SLOTS-1:0]    mask_x;
	logic [SLOTS-1:0]    en_x;
	logic [SLOTS-1:0]    pend_mid;
	logic [SLOTS-1:0]    cand;
	logic                is_req;
	logic                is_int;
	logic                is_err;
	logic                report;
	logic                busy_mid;
	logic                start;
	logic [SEL_W-1:0]    pick;
	res_t                rep_res;
	res_t                st_res;
	res_t                wr_data0;
	res_t                rd_data;
	logic [1:0]          wr_cnt;

	// only the slots that the 8-bit fields carry
	for (genvar i = 0; i < SLOTS; i++) begin : g_ext
		if (i < MASK_W) begin : g_in
			assign mask_x[i] = mask_s1[i];
			assign en_x[i]   = slot_enable_q[i];
		end else begin : g_out
			assign mask_x[i] = 1'b0;
			assign en_x[i]   = 1'b0;
		end
	end

	assign fire      = valid_s1 && room2;
	assign req.ready = !valid_s1 || fire;

	assign is_req = (op_s1 == OP_REQUEST);
	assign is_int = (op_s1 == OP_INTERRUPT);
	assign is_err = (op_s1 == OP_ERROR);

	assign pend_mid = is_req ? (pending_q | (mask_x & en_x)) : pending_q;
	assign report   = busy_q && (is_int || is_err);
	assign busy_mid = busy_q && !(is_int || is_err);
	assign cand     = pend_mid & en_x;
	assign start    = (is_req || is_int) && !busy_mid && ready_s1 && (cand != '0);

	acrr_rr_pick #(
		.SLOTS(SLOTS)
	) u_pick (
		.cand(cand),
		.pos (rr_q),
		.idx (pick)
	);

	always_comb begin
		rep_res.kind  = (is_int && eoc_s1) ? KIND_DONE : KIND_FAIL;
		rep_res.slot  = SLOT_W'(active_q);
		rep_res.value = (is_int && eoc_s1) ? (sample_s1 & SAMPLE_KEEP) : '0;
		rep_res.last  = !start;
		st_res.kind   = KIND_START;
		st_res.slot   = SLOT_W'(pick);
		st_res.value  = '0;
		st_res.last   = 1'b1;
	end

	assign wr_data0 = report ? rep_res : st_res;
	assign wr_cnt   = fire ? (2'(report) + 2'(start)) : 2'd0;

	acrr_res_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (wr_cnt),
		.wr_data0(wr_data0),
		.wr_data1(st_res),
		.room2   (room2),
		.rd_valid(res.valid),
		.rd_ready(res.ready),
		.rd_data (rd_data)
	);

	assign res.kind  = rd_data.kind;
	assign res.slot  = rd_data.slot;
	assign res.value = rd_data.value;
	assign res.last  = rd_data.last;

	// request register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1     <= req.operation;
			mask_s1   <= req.request_mask;
			eoc_s1    <= req.eoc_flag;
			sample_s1 <= req.sample;
			ready_s1  <= req.adc_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_enable_q <= '0;
			pending_q     <= '0;
			rr_q          <= '0;
			busy_q        <= 1'b0;
			active_q      <= '0;
		end else begin
			if (cfg_we) begin
				slot_enable_q <= cfg_wdata;
			end
			if (fire) begin
				busy_q <= busy_mid || start;
				if (start) begin
					pending_q <= pend_mid & ~(SLOTS'(1) << pick);
					rr_q      <= pick;
					active_q  <= pick;
				end else begin
					pending_q <= pend_mid;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/acrr_rr_pick.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acrr_rr_pick
// round-robin pick: first candidate slot after the current position, wrapping
// ----------------------------------------------------------------------------
module acrr_rr_pick #(
	parameter int SLOTS = 8
) (
	input  wire logic [SLOTS-1:0]         cand,
	input  wire logic [$clog2(SLOTS)-1:0] pos,
	output logic      [$clog2(SLOTS)-1:0] idx
);

	localparam int SEL_W = $clog2(SLOTS);
	localparam int SUM_W = SEL_W + 1;

	logic [2*SLOTS-1:0] dbl;
	logic [SLOTS-1:0]   window;
	logic [SEL_W-1:0]   k;
	logic [SUM_W-1:0]   sum;

	assign dbl    = {cand, cand} >> (SUM_W'(pos) + SUM_W'(1));
	assign window = dbl[SLOTS-1:0];

	// lowest set bit of the rotated window
	always_comb begin
		k = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (window[i]) begin
				k = SEL_W'(i);
			end
		end
	end

	assign sum = SUM_W'(pos) + SUM_W'(1) + SUM_W'(k);
	assign idx = (sum >= SUM_W'(SLOTS)) ? SEL_W'(sum - SUM_W'(SLOTS)) : SEL_W'(sum);

endmodule
`default_nettype wire

// ----- rtl/acrr_res_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acrr_res_fifo
// result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module acrr_res_fifo import acrr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [1:0] wr_cnt,
	input  wire res_t wr_data0,
	input  wire res_t wr_data1,
	output logic      room2,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output res_t      rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_p1;
	logic [PTR_W-1:0] tail_p1;
	logic [PTR_W-1:0] tail_p2;
	logic             pop;

	assign head_p1 = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_p1 = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign tail_p2 = (tail_p1 == PTR_W'(DEPTH - 1)) ? '0 : tail_p1 + PTR_W'(1);

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[head_q];
	assign pop      = rd_valid && rd_ready;
	assign room2    = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[tail_q] <= wr_data0;
		end
		if (wr_cnt == 2'd2) begin
			mem_q[tail_p1] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_p1;
			end
			if (wr_cnt == 2'd1) begin
				tail_q <= tail_p1;
			end else if (wr_cnt == 2'd2) begin
				tail_q <= tail_p2;
			end
			count_q <= count_q + CNT_W'(wr_cnt) - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- dv/acrr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrr_checker
// Watches the request and result channels of the conversion scheduler. It
// keeps its own copy of the slot enables, pending bits, round-robin position
// and busy flag, works out the report and start results of each accepted
// request, and compares every result in order, field by field.
// ----------------------------------------------------------------------------
module acrr_checker import acrr_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [EN_W-1:0] cfg_wdata,
	acrr_req_if                  req,
	acrr_res_if                  res,
	output int                   fail_count,
	output int                   outstanding
);

	logic [EN_W-1:0]   slot_en;
	logic [MASK_W-1:0] pend;
	logic [SLOT_W-1:0] rr_pos;
	logic [SLOT_W-1:0] act_slot;
	logic              conv_busy;
	res_t              conv_results_q[$];
	res_t              step_results[$];

	function automatic void add_result(input logic [KIND_W-1:0] kind,
		input logic [SAMPLE_W-1:0] value);
		res_t r;
		r.kind  = kind;
		r.slot  = act_slot;
		r.value = value;
		r.last  = 1'b0;
		step_results.push_back(r);
	endfunction

	// round-robin pick of the next enabled pending slot
	function automatic void launch_next(input logic adc_rdy);
		logic [MASK_W-1:0] cand;
		int                i;
		cand = pend & slot_en;
		if (conv_busy || !adc_rdy || cand == '0)
			return;
		for (i = 0; i < (1 << SLOT_W); i++) begin
			rr_pos = rr_pos + 1'b1;
			if (cand[rr_pos])
				break;
		end
		pend[rr_pos] = 1'b0;
		act_slot     = rr_pos;
		conv_busy    = 1'b1;
		add_result(KIND_START, '0);
	endfunction

	function automatic void predict_request(input logic [OP_W-1:0] op,
		input logic [MASK_W-1:0] mask, input logic eoc,
		input logic [SAMPLE_W-1:0] smp, input logic adc_rdy);
		res_t r;
		step_results.delete();
		case (op)
		OP_REQUEST: begin
			pend = pend | (mask & slot_en);
			launch_next(adc_rdy);
		end
		OP_INTERRUPT: begin
			if (conv_busy) begin
				if (eoc)
					add_result(KIND_DONE, smp);
				else
					add_result(KIND_FAIL, '0);
				conv_busy = 1'b0;
			end
			launch_next(adc_rdy);
		end
		OP_ERROR: begin
			if (conv_busy) begin
				add_result(KIND_FAIL, '0);
				conv_busy = 1'b0;
			end
		end
		default: ;
		endcase
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i])
			conv_results_q.push_back(step_results[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			slot_en   = '0;
			pend      = '0;
			rr_pos    = '0;
			act_slot  = '0;
			conv_busy = 1'b0;
			conv_results_q.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				slot_en = cfg_wdata;
			if (res.valid && res.ready) begin
				if (conv_results_q.size() == 0) begin
					$error("unexpected result: kind %0d slot %0d value %0h last %0d",
						res.kind, res.slot, res.value, res.last);
					fail_count++;
				end else begin
					want = conv_results_q.pop_front();
					if (res.kind !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d", want.kind, res.kind);
						fail_count++;
					end
					if (res.slot !== want.slot) begin
						$error("slot mismatch: expected %0d, actual %0d", want.slot, res.slot);
						fail_count++;
					end
					if (res.value !== want.value) begin
						$error("value mismatch: expected %0h, actual %0h",
							want.value, res.value);
						fail_count++;
					end
					if (res.last !== want.last) begin
						$error("last mismatch: expected %0d, actual %0d", want.last, res.last);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				predict_request(req.operation, req.request_mask, req.eoc_flag,
					req.sample, req.adc_ready);
			outstanding = conv_results_q.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the conversion scheduler with directed requests, interrupts and
// error events, then with random traffic under several slot enable settings,
// while both channels stall at random outside one steady phase. A separate
// checker predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import acrr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 6;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [EN_W-1:0] cfg_wdata;
	logic            steady;
	int              fail_count;
	int              outstanding;
	int              quiet_cycles;

	acrr_req_if req ();
	acrr_res_if res ();

	adc_round_robin_conversion_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	acrr_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req),
		.res         (res),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= steady || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_req(input logic [OP_W-1:0] op, input logic [MASK_W-1:0] mask,
		input logic eoc, input logic [SAMPLE_W-1:0] smp, input logic adc_rdy);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 15) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.operation    <= op;
		req.request_mask <= mask;
		req.eoc_flag     <= eoc;
		req.sample       <= smp;
		req.adc_ready    <= adc_rdy;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_slot_enable(input logic [EN_W-1:0] en);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_traffic(input int count);
		int                  sent;
		int                  r;
		logic [OP_W-1:0]     op;
		logic [MASK_W-1:0]   mask;
		logic [SAMPLE_W-1:0] smp;
		logic                eoc;
		logic                adc_rdy;
		sent = 0;
		while (sent < count) begin
			r       = $urandom_range(99);
			mask    = ($urandom_range(1) == 1) ? MASK_W'($urandom_range(255)) :
				MASK_W'(1 << $urandom_range(MASK_W - 1));
			eoc     = ($urandom_range(9) != 0);
			adc_rdy = ($urandom_range(7) != 0);
			smp     = SAMPLE_W'($urandom);
			if (r < 40)
				op = OP_REQUEST;
			else if (r < 82)
				op = OP_INTERRUPT;
			else if (r < 94)
				op = OP_ERROR;
			else
				op = OP_UNUSED;
			send_req(op, mask, eoc, smp, adc_rdy);
			if (op != OP_UNUSED)
				sent++;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		steady           = 1'b0;
		quiet_cycles     = 0;
		req.valid        = 1'b0;
		req.operation    = OP_REQUEST;
		req.request_mask = '0;
		req.eoc_flag     = 1'b0;
		req.sample       = '0;
		req.adc_ready    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		set_slot_enable(8'hFF);
		send_req(OP_REQUEST,   8'h00, 1'b0, 12'h000, 1'b1);
		send_req(OP_REQUEST,   8'hFF, 1'b0, 12'h000, 1'b0);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h123, 1'b1);
		send_req(OP_REQUEST,   8'h80, 1'b0, 12'h000, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'hFFF, 1'b1);
		send_req(OP_INTERRUPT, 8'hFF, 1'b0, 12'hFFF, 1'b0);
		send_req(OP_ERROR,     8'hFF, 1'b1, 12'hFFF, 1'b1);
		send_req(OP_UNUSED,    8'hFF, 1'b1, 12'hFFF, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h7FF, 1'b0);
		send_req(OP_REQUEST,   8'h01, 1'b0, 12'h000, 1'b1);
		send_req(OP_ERROR,     8'h00, 1'b0, 12'h000, 1'b1);
		send_req(OP_ERROR,     8'h00, 1'b0, 12'h000, 1'b1);
		send_req(OP_REQUEST,   8'h00, 1'b0, 12'h000, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h000, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'hAAA, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h555, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h800, 1'b1);
		send_req(OP_REQUEST,   8'hF0, 1'b0, 12'h000, 1'b0);
		// upper slots stay pending while disabled
		set_slot_enable(8'h0F);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h001, 1'b1);
		send_req(OP_REQUEST,   8'h0C, 1'b0, 12'h000, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h3C3, 1'b1);
		send_req(OP_ERROR,     8'h00, 1'b0, 12'h000, 1'b0);
		set_slot_enable(8'hFF);
		send_req(OP_INTERRUPT, 8'h00, 1'b1, 12'h000, 1'b1);
		send_req(OP_INTERRUPT, 8'h00, 1'b0, 12'hC3C, 1'b1);

		// random part
		random_traffic(300);
		steady <= 1'b1;
		random_traffic(150);
		@(negedge clk);
		req.valid <= 1'b0;
		steady    <= 1'b0;
		set_slot_enable(EN_W'($urandom_range(1, 254)));
		random_traffic(250);
		set_slot_enable(8'h01);
		random_traffic(120);
		set_slot_enable(8'h80);
		random_traffic(120);
		set_slot_enable(EN_W'($urandom_range(1, 254)));
		random_traffic(220);
		set_slot_enable(8'h00);
		random_traffic(40);

		drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- adc_round_robin_conversion_scheduler_core.f -----
rtl/acrr_pkg.sv
rtl/acrr_if.sv
rtl/acrr_rr_pick.sv
rtl/acrr_res_fifo.sv
rtl/adc_round_robin_conversion_scheduler_core.sv
dv/acrr_checker.sv
dv/tb_top.sv
